// ===== rtl/core/gcc_pkg.sv =====
// ----------------------------------------------------------------------------
// GPS calendar converter package
// Shared item type, opcodes, time constants and small lookup functions.
// ----------------------------------------------------------------------------
package gcc_pkg;

  typedef enum logic {
    OpCalToGps = 1'b0,
    OpGpsToCal = 1'b1
  } op_e;

  // Pipeline depth, split between the front (to MJD) and back (from MJD) halves
  localparam int FrontStages = 4;
  localparam int BackStages  = 6;
  localparam int NumStages   = FrontStages + BackStages;

  // Time units in microseconds
  localparam logic [39:0] UsPerDay  = 40'd86400000000;
  localparam logic [39:0] UsPerHour = 40'd3600000000;
  localparam logic [39:0] UsPerMin  = 40'd60000000;
  localparam logic [39:0] WeekUsMax = 40'd604799999999;

  // Calendar field limits
  localparam logic [11:0] YearFirst  = 12'd1980;
  localparam logic [11:0] YearLast   = 12'd2099;
  localparam logic [3:0]  MonthLast  = 4'd12;
  localparam logic [4:0]  HourLast   = 5'd23;
  localparam logic [5:0]  MinuteLast = 6'd59;
  localparam logic [25:0] SecUsLast  = 26'd59999999;

  // Day numbers
  localparam logic [16:0] MjdGpsEpoch = 17'd44244;
  localparam logic [16:0] MjdLast     = 17'd88068;
  localparam logic [19:0] MjdOffset   = 20'd679019;
  localparam logic [19:0] DayNumFirst = 20'd723263;   // MjdOffset + MjdGpsEpoch
  localparam logic [19:0] DayNumLast  = 20'd767087;   // MjdOffset + MjdLast
  localparam logic [23:0] JdBias      = 24'd2401538;  // 2400001 + 1537
  localparam logic [27:0] CentBias    = 28'd240141590; // JdBias * 100 - 12210
  localparam logic [27:0] CentDays    = 28'd36525;
  localparam logic [12:0] YearBase    = 13'd4715;

  // Reciprocals for division by constants: q0 = (x * Recip) >> Shift
  localparam logic [32:0] RecipWeek = 33'd74899;  // /7, exact for x < 2^16
  localparam int          ShiftWeek = 19;
  localparam logic [32:0] RecipDay  = 33'd12;     // /42187500 after >> 11
  localparam int          ShiftDay  = 29;
  localparam logic [32:0] RecipHour = 33'd38;     // /3515625 after >> 10
  localparam int          ShiftHour = 27;
  localparam logic [30:0] RecipMin  = 31'd71;     // /234375 after >> 8
  localparam int          ShiftMin  = 24;
  localparam logic [40:0] RecipCent = 41'd7349;   // /36525
  localparam int          ShiftCent = 28;

  typedef struct packed {
    op_e         op;
    logic        err;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [25:0] sec_us;
    logic [12:0] week;
    logic [39:0] wsec;
    logic [16:0] mjd;
    logic [36:0] frac;
    logic [3:0]  qd;    // short quotient scratch
    logic [39:0] acc;   // remainder scratch for the clock split
    logic [27:0] n;     // scratch for the date split
    logic [12:0] c;     // year-like count from the date split
  } item_t;

  // floor(30.6001 * e)
  function automatic logic [8:0] floor30(input logic [3:0] e);
    logic [8:0] r;
    unique case (e)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd30;
      4'd2:  r = 9'd61;
      4'd3:  r = 9'd91;
      4'd4:  r = 9'd122;
      4'd5:  r = 9'd153;
      4'd6:  r = 9'd183;
      4'd7:  r = 9'd214;
      4'd8:  r = 9'd244;
      4'd9:  r = 9'd275;
      4'd10: r = 9'd306;
      4'd11: r = 9'd336;
      4'd12: r = 9'd367;
      4'd13: r = 9'd397;
      4'd14: r = 9'd428;
      4'd15: r = 9'd459;
    endcase
    return r;
  endfunction

  // floor(bd / 30.6001): count the month boundaries that bd passes
  function automatic logic [3:0] month_code(input logic [9:0] bd);
    logic [3:0] e;
    e = '0;
    for (int k = 1; k < 16; k++) begin
      if (bd > 10'(floor30(4'(k)))) begin
        e = 4'(k);
      end
    end
    return e;
  endfunction

endpackage

// ===== rtl/core/gps_calendar_time_converter_unit.sv =====
// An accepted request passes through all ten register stages before its result reaches the outputs.
// Throughput: one request per cycle while out_ready_i is high; each of the ten register stages holds one
// request, and a stage whose output is taken accepts a new one the same cycle.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// GPS calendar time converter
// Converts civil date-time to GPS week and microseconds of week or back,
// through the Modified Julian Day, in a ten-stage pipeline.
// ----------------------------------------------------------------------------
module gps_calendar_time_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [25:0] second_us_i,
  input  logic [12:0] gps_week_i,
  input  logic [39:0] week_second_us_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [4:0]  out_hour_o,
  output logic [5:0]  out_minute_o,
  output logic [25:0] out_second_us_o,
  output logic [12:0] out_week_o,
  output logic [39:0] out_week_second_us_o,
  output logic [16:0] mjd_day_o,
  output logic [36:0] day_fraction_us_o,
  output logic        range_error_o
);

  localparam int NStg = gcc_pkg::NumStages;

  // One valid bit per stage; a stage loads whenever it is empty or the stage
  // after it moves on, so bubbles collapse and a stall backs up stage by stage.
  logic [NStg-1:0] valid_q;
  logic [NStg-1:0] valid_d;
  logic [NStg-1:0] stage_en;

  gcc_pkg::item_t in_item;
  gcc_pkg::item_t mid_item;
  gcc_pkg::item_t out_item;

  // Ready chain from the output back to the input
  always_comb begin
    stage_en[NStg-1] = !valid_q[NStg-1] || out_ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  // Advance valid bits in the stages that load, hold them elsewhere
  assign valid_d = ({valid_q[NStg-2:0], in_valid_i} & stage_en) | (valid_q & ~stage_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = valid_q[NStg-1];

  // Pack the request; scratch fields start at zero
  always_comb begin
    in_item        = '0;
    in_item.op     = gcc_pkg::op_e'(opcode_i);
    in_item.year   = year_i;
    in_item.month  = month_i;
    in_item.day    = day_i;
    in_item.hour   = hour_i;
    in_item.minute = minute_i;
    in_item.sec_us = second_us_i;
    in_item.week   = gps_week_i;
    in_item.wsec   = week_second_us_i;
  end

  // Front: either direction down to MJD plus microseconds of day
  gcc_to_mjd u_to_mjd (
    .clk_i  (clk_i),
    .en_i   (stage_en[gcc_pkg::FrontStages-1:0]),
    .item_i (in_item),
    .item_o (mid_item)
  );

  // Back: MJD back up to a calendar date and clock time, result formatting
  gcc_from_mjd u_from_mjd (
    .clk_i  (clk_i),
    .en_i   (stage_en[NStg-1:gcc_pkg::FrontStages]),
    .item_i (mid_item),
    .item_o (out_item)
  );

  // The last stage register drives the result directly
  assign out_year_o           = out_item.year;
  assign out_month_o          = out_item.month;
  assign out_day_o            = out_item.day;
  assign out_hour_o           = out_item.hour;
  assign out_minute_o         = out_item.minute;
  assign out_second_us_o      = out_item.sec_us;
  assign out_week_o           = out_item.week;
  assign out_week_second_us_o = out_item.wsec;
  assign mjd_day_o            = out_item.mjd;
  assign day_fraction_us_o    = out_item.frac;
  assign range_error_o        = out_item.err;

endmodule

// ===== rtl/core/gcc_to_mjd.sv =====
// ----------------------------------------------------------------------------
// GPS calendar converter, front half
// Four stages that bring either input form to an MJD day plus microseconds of
// day, and finish the calendar-to-GPS direction.
// ----------------------------------------------------------------------------
module gcc_to_mjd (
  input  logic                            clk_i,
  input  logic [gcc_pkg::FrontStages-1:0] en_i,
  input  gcc_pkg::item_t                  item_i,
  output gcc_pkg::item_t                  item_o
);

  gcc_pkg::item_t s1_d, s1_q, s2_d, s2_q, s3_d, s3_q, s4_d, s4_q;

  logic [11:0] cal_y;
  logic [3:0]  cal_m;
  logic [21:0] cal_ydays;
  logic [19:0] cal_t;
  logic [36:0] cal_frac;
  logic        cal_bad;
  logic [15:0] s2_x;
  logic [15:0] s3_x;

  // Stage 1: validate, day number and time of day (calendar); range check and day estimate (GPS)
  always_comb begin
    cal_y     = (item_i.month <= 4'd2) ? item_i.year - 12'd1 : item_i.year;
    cal_m     = (item_i.month <= 4'd2) ? item_i.month + 4'd12 : item_i.month;
    cal_ydays = 22'(cal_y) * 22'd1461;
    cal_t     = 20'(cal_ydays >> 2) + 20'(gcc_pkg::floor30(cal_m + 4'd1))
              + 20'(item_i.day);
    cal_frac  = 37'(item_i.hour) * 37'(gcc_pkg::UsPerHour)
              + 37'(item_i.minute) * 37'(gcc_pkg::UsPerMin)
              + 37'(item_i.sec_us);
    cal_bad   = (item_i.year < gcc_pkg::YearFirst) || (item_i.year > gcc_pkg::YearLast)
             || (item_i.month == 4'd0) || (item_i.month > gcc_pkg::MonthLast)
             || (item_i.day == 5'd0) || (item_i.hour > gcc_pkg::HourLast)
             || (item_i.minute > gcc_pkg::MinuteLast)
             || (item_i.sec_us > gcc_pkg::SecUsLast)
             || (cal_t < gcc_pkg::DayNumFirst) || (cal_t > gcc_pkg::DayNumLast);
    s1_d = item_i;
    if (item_i.op == gcc_pkg::OpCalToGps) begin
      s1_d.err  = cal_bad;
      s1_d.mjd  = 17'(cal_t - gcc_pkg::MjdOffset);
      s1_d.frac = cal_frac;
    end else begin
      s1_d.err = item_i.wsec > gcc_pkg::WeekUsMax;
      s1_d.qd  = 4'((33'(item_i.wsec >> 11) * gcc_pkg::RecipDay) >> gcc_pkg::ShiftDay);
    end
  end

  // Stage 2: week quotient (calendar); day remainder and MJD estimate (GPS)
  always_comb begin
    s2_x = 16'(s1_q.mjd - gcc_pkg::MjdGpsEpoch);
    s2_d = s1_q;
    if (s1_q.op == gcc_pkg::OpCalToGps) begin
      s2_d.week = 13'((33'(s2_x) * gcc_pkg::RecipWeek) >> gcc_pkg::ShiftWeek);
    end else begin
      s2_d.acc = s1_q.wsec - 40'(s1_q.qd) * gcc_pkg::UsPerDay;
      s2_d.mjd = gcc_pkg::MjdGpsEpoch + 17'(s1_q.week) * 17'd7 + 17'(s1_q.qd);
    end
  end

  // Stage 3: day of week (calendar); fix up the day estimate (GPS)
  always_comb begin
    s3_x = 16'(s2_q.mjd - gcc_pkg::MjdGpsEpoch);
    s3_d = s2_q;
    if (s2_q.op == gcc_pkg::OpCalToGps) begin
      s3_d.qd = 4'(s3_x - 16'(s2_q.week) * 16'd7);
    end else if (s2_q.acc >= gcc_pkg::UsPerDay) begin
      s3_d.mjd  = s2_q.mjd + 17'd1;
      s3_d.frac = 37'(s2_q.acc - gcc_pkg::UsPerDay);
    end else begin
      s3_d.frac = 37'(s2_q.acc);
    end
  end

  // Stage 4: seconds of week (calendar); range check, century numerator and
  // hour estimate (GPS)
  always_comb begin
    s4_d = s3_q;
    if (s3_q.op == gcc_pkg::OpCalToGps) begin
      s4_d.wsec = 40'(s3_q.qd) * gcc_pkg::UsPerDay + 40'(s3_q.frac);
    end else begin
      s4_d.err  = s3_q.err || (s3_q.mjd > gcc_pkg::MjdLast);
      s4_d.n    = 28'(s3_q.mjd) * 28'd100 + gcc_pkg::CentBias;
      s4_d.hour = 5'((33'(s3_q.frac >> 10) * gcc_pkg::RecipHour) >> gcc_pkg::ShiftHour);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q <= s1_d;
    end
    if (en_i[1]) begin
      s2_q <= s2_d;
    end
    if (en_i[2]) begin
      s3_q <= s3_d;
    end
    if (en_i[3]) begin
      s4_q <= s4_d;
    end
  end

  assign item_o = s4_q;

endmodule

// ===== rtl/core/gcc_from_mjd.sv =====
// ----------------------------------------------------------------------------
// GPS calendar converter, back half
// Six stages that split an MJD day into year, month and day and the
// microseconds of day into hour, minute and second, then format the result.
// ----------------------------------------------------------------------------
module gcc_from_mjd (
  input  logic                           clk_i,
  input  logic [gcc_pkg::BackStages-1:0] en_i,
  input  gcc_pkg::item_t                 item_i,
  output gcc_pkg::item_t                 item_o
);

  gcc_pkg::item_t s5_d, s5_q, s6_d, s6_q, s7_d, s7_q, s8_d, s8_q, s9_d, s9_q;
  gcc_pkg::item_t s10_d, s10_q;

  logic [39:0] s9_acc;
  logic [3:0]  s10_mo;

  // Stage 5: century quotient estimate; hour remainder
  always_comb begin
    s5_d = item_i;
    if (item_i.op == gcc_pkg::OpGpsToCal) begin
      s5_d.c   = 13'((41'(item_i.n) * gcc_pkg::RecipCent) >> gcc_pkg::ShiftCent);
      s5_d.acc = 40'(item_i.frac) - 40'(item_i.hour) * gcc_pkg::UsPerHour;
    end
  end

  // Stage 6: century remainder; fix up the hour
  always_comb begin
    s6_d = s5_q;
    if (s5_q.op == gcc_pkg::OpGpsToCal) begin
      s6_d.n = s5_q.n - 28'(s5_q.c) * gcc_pkg::CentDays;
      if (s5_q.acc >= gcc_pkg::UsPerHour) begin
        s6_d.hour = s5_q.hour + 5'd1;
        s6_d.acc  = s5_q.acc - gcc_pkg::UsPerHour;
      end
    end
  end

  // Stage 7: fix up the year count; minute estimate
  always_comb begin
    s7_d = s6_q;
    if (s6_q.op == gcc_pkg::OpGpsToCal) begin
      if (s6_q.n >= gcc_pkg::CentDays) begin
        s7_d.c = s6_q.c + 13'd1;
      end
      s7_d.minute = 6'((31'(s6_q.acc[31:8]) * gcc_pkg::RecipMin) >> gcc_pkg::ShiftMin);
    end
  end

  // Stage 8: day within the shifted year; minute remainder
  always_comb begin
    s8_d = s7_q;
    if (s7_q.op == gcc_pkg::OpGpsToCal) begin
      s8_d.n   = 28'(24'(s7_q.mjd) + gcc_pkg::JdBias - ((24'(s7_q.c) * 24'd1461) >> 2));
      s8_d.acc = s7_q.acc - 40'(s7_q.minute) * gcc_pkg::UsPerMin;
    end
  end

  // Stage 9: month code; fix up the minute and take the seconds
  always_comb begin
    s9_acc = s8_q.acc;
    s9_d   = s8_q;
    if (s8_q.op == gcc_pkg::OpGpsToCal) begin
      s9_d.qd = gcc_pkg::month_code(s8_q.n[9:0]);
      if (s8_q.acc >= gcc_pkg::UsPerMin) begin
        s9_d.minute = s8_q.minute + 6'd1;
        s9_acc      = s8_q.acc - gcc_pkg::UsPerMin;
      end
      s9_d.acc    = s9_acc;
      s9_d.sec_us = 26'(s9_acc);
    end
  end

  // Stage 10: day, month and year; zero the result on a range error
  always_comb begin
    s10_mo = (s9_q.qd < 4'd14) ? s9_q.qd - 4'd1 : s9_q.qd - 4'd13;
    s10_d  = s9_q;
    if (s9_q.op == gcc_pkg::OpGpsToCal) begin
      s10_d.day   = 5'(s9_q.n[9:0] - 10'(gcc_pkg::floor30(s9_q.qd)));
      s10_d.month = s10_mo;
      s10_d.year  = 12'(s9_q.c - gcc_pkg::YearBase - 13'(s10_mo >= 4'd3));
    end
    if (s9_q.err) begin
      s10_d     = '0;
      s10_d.op  = s9_q.op;
      s10_d.err = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s5_q <= s5_d;
    end
    if (en_i[1]) begin
      s6_q <= s6_d;
    end
    if (en_i[2]) begin
      s7_q <= s7_d;
    end
    if (en_i[3]) begin
      s8_q <= s8_d;
    end
    if (en_i[4]) begin
      s9_q <= s9_d;
    end
    if (en_i[5]) begin
      s10_q <= s10_d;
    end
  end

  assign item_o = s10_q;

endmodule
